// ===== sv/mbk_pkg.sv =====
// ----------------------------------------------------------------------------
// mbk_pkg: shared types and codes for the multi-button key qualifier
// Phase and event codes, per-button state record, fixed field widths.
// ----------------------------------------------------------------------------
package mbk_pkg;

	localparam int IDX_W   = 3;   // button_index field
	localparam int CNT_W   = 8;   // hold counter and thresholds
	localparam int EV_W    = 2;   // key_event field
	localparam int PH_W    = 2;
	localparam int CFG_IDX_W = 2;

	// button phases
	localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
	localparam logic [PH_W-1:0] PH_CONFIRM = 2'd1;
	localparam logic [PH_W-1:0] PH_PRESSED = 2'd2;
	localparam logic [PH_W-1:0] PH_LONG    = 2'd3;

	// key events
	localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EV_W-1:0] EV_CLICK  = 2'd1;
	localparam logic [EV_W-1:0] EV_HELD   = 2'd2;
	localparam logic [EV_W-1:0] EV_REPEAT = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 2'd1;

	localparam logic [CNT_W-1:0] CFG_RESET_VALUE = 8'd100;

	typedef struct packed {
		logic [PH_W-1:0]  phase;
		logic [CNT_W-1:0] count;
	} state_t;

endpackage

// ===== sv/mbk_ram.sv =====
// ----------------------------------------------------------------------------
// mbk_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mbk_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 5
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/mbk_update.sv =====
// ----------------------------------------------------------------------------
// mbk_update: per-button next-state logic
// Debounce, click, long press and repeat decision for one sample.
// ----------------------------------------------------------------------------
module mbk_update (
	input  mbk_pkg::state_t                cur,
	input  logic                           pin_level,
	input  logic [mbk_pkg::CNT_W-1:0]      hold_threshold,
	input  logic [mbk_pkg::CNT_W-1:0]      repeat_period,
	output mbk_pkg::state_t                nxt,
	output logic [mbk_pkg::EV_W-1:0]       key_event
);

	logic [mbk_pkg::CNT_W-1:0] cnt_inc;

	assign cnt_inc = cur.count + mbk_pkg::CNT_W'(1);   // 8-bit wrap

	always_comb begin
		nxt       = cur;
		key_event = mbk_pkg::EV_NONE;
		unique case (cur.phase)
			mbk_pkg::PH_IDLE: begin
				if (!pin_level) begin
					nxt.phase = mbk_pkg::PH_CONFIRM;
				end
			end
			mbk_pkg::PH_CONFIRM: begin
				if (!pin_level) begin
					nxt.phase = mbk_pkg::PH_PRESSED;
					nxt.count = '0;
				end else begin
					nxt.phase = mbk_pkg::PH_IDLE;
				end
			end
			mbk_pkg::PH_PRESSED: begin
				if (pin_level) begin
					nxt.phase = mbk_pkg::PH_IDLE;
					key_event = mbk_pkg::EV_CLICK;
				end else if (cnt_inc >= hold_threshold) begin
					nxt.phase = mbk_pkg::PH_LONG;
					nxt.count = '0;
					key_event = mbk_pkg::EV_HELD;
				end else begin
					nxt.count = cnt_inc;
				end
			end
			default: begin
				if (pin_level) begin
					nxt.phase = mbk_pkg::PH_IDLE;
				end else if (cnt_inc >= repeat_period) begin
					nxt.count = '0;
					key_event = mbk_pkg::EV_REPEAT;
				end else begin
					nxt.count = cnt_inc;
					key_event = mbk_pkg::EV_HELD;
				end
			end
		endcase
	end

endmodule

// ===== sv/multi_button_click_long_press_top.sv =====
// ----------------------------------------------------------------------------
// multi_button_click_long_press_top: multi-button key qualifier
// Per-button debounce, click, long press and repeat from scan samples.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* stream: one scan sample per transfer, s_tdata = {pin_level, index}.
//    pin_level 0 means pressed. Indexes at or above NUM_BUTTONS are answered
//    with "none" and leave all state alone.
//  - m_* stream: exactly one key_event per accepted sample, in order.
//  - cfg_*: register writes (0 hold_threshold, 1 repeat_period), always
//    ready; other indexes are ignored. Write only while the block is idle.
//  - Pipeline: an accepted sample passes the update stage, then the output
//    register that drives m_tvalid. Throughput: one sample per cycle while
//    m_tready keeps the output draining, set by the read-modify-write of the
//    per-button state RAM (read issued at accept, write back when the update
//    stage fires, last write forwarded to the next read).
//  - Reset: all buttons idle with zero count (per-entry valid flags, so no
//    clearing pass), both thresholds 100, pipeline empty.
//  - Stall: when m_tready is low the output register holds; one more sample
//    waits in the update stage, then s_tready drops until space frees up.
// ----------------------------------------------------------------------------
module multi_button_click_long_press_top #(
	parameter int NUM_BUTTONS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [2:0] button_index, [3] pin_level
	// event stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [1:0] key_event
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mbk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbk_pkg::CNT_W-1:0]         cfg_data
);

	localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int CMP_W  = 8;  // wide enough for any NUM_BUTTONS in range

	// input fields
	logic [mbk_pkg::IDX_W-1:0] button_index;
	logic                      pin_level;
	logic                      in_range;
	logic                      s_xfer;

	// config registers
	logic [mbk_pkg::CNT_W-1:0] hold_threshold_q;
	logic [mbk_pkg::CNT_W-1:0] repeat_period_q;

	// update stage
	logic                      valid_s1;
	logic                      inrange_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic                      pin_s1;
	logic                      s1_fire;

	// state RAM and write-back tracking
	mbk_pkg::state_t           ram_rdata;
	mbk_pkg::state_t           cur_state;
	mbk_pkg::state_t           nxt_state;
	logic [mbk_pkg::EV_W-1:0]  s1_event;
	logic                      ram_we;
	logic [NUM_BUTTONS-1:0]    entry_valid_q;
	logic                      wb_valid_q;
	logic [ADDR_W-1:0]         wb_addr_q;
	mbk_pkg::state_t           wb_data_q;

	// output register
	logic                      out_valid_q;
	logic [mbk_pkg::EV_W-1:0]  out_event_q;

	assign button_index = s_tdata[mbk_pkg::IDX_W-1:0];
	assign pin_level    = s_tdata[mbk_pkg::IDX_W];
	assign in_range     = CMP_W'(button_index) < CMP_W'(NUM_BUTTONS);

	// stage moves when the output register is free or being drained
	assign s1_fire  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_fire;
	assign s_xfer   = s_tvalid && s_tready;

	// ---- configuration ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_threshold_q <= mbk_pkg::CFG_RESET_VALUE;
			repeat_period_q  <= mbk_pkg::CFG_RESET_VALUE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mbk_pkg::REG_HOLD_THRESHOLD: hold_threshold_q <= cfg_data;
				mbk_pkg::REG_REPEAT_PERIOD:  repeat_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- state RAM: read at accept, write back from the update stage ----
	assign ram_we = s1_fire && inrange_s1;

	mbk_ram #(
		.WIDTH ($bits(mbk_pkg::state_t)),
		.DEPTH (NUM_BUTTONS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (nxt_state),
		.re    (s_xfer),
		.raddr (ADDR_W'(button_index)),
		.rdata (ram_rdata)
	);

	// ---- update stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			inrange_s1 <= in_range;
			addr_s1    <= ADDR_W'(button_index);
			pin_s1     <= pin_level;
		end
	end

	// last write wins over RAM data (covers write and read at the same edge);
	// never-written entries read as idle with zero count
	always_comb begin
		if (wb_valid_q && (wb_addr_q == addr_s1)) begin
			cur_state = wb_data_q;
		end else if (entry_valid_q[addr_s1]) begin
			cur_state = ram_rdata;
		end else begin
			cur_state = '0;
		end
	end

	mbk_update u_update (
		.cur            (cur_state),
		.pin_level      (pin_s1),
		.hold_threshold (hold_threshold_q),
		.repeat_period  (repeat_period_q),
		.nxt            (nxt_state),
		.key_event      (s1_event)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			wb_valid_q    <= 1'b0;
		end else if (ram_we) begin
			entry_valid_q[addr_s1] <= 1'b1;
			wb_valid_q             <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			wb_addr_q <= addr_s1;
			wb_data_q <= nxt_state;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_event_q <= inrange_s1 ? s1_event : mbk_pkg::EV_NONE;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8 - mbk_pkg::EV_W){1'b0}}, out_event_q};

endmodule

// ===== sv/mbk_checker.sv =====
// ----------------------------------------------------------------------------
// mbk_checker: port-level checks for the key qualifier
// Watches the top-level streams; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module mbk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// stalled event holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("event changed while stalled");

	// every accepted sample is followed by a raised m_tvalid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##1 m_tvalid)
		else $error("no event after accepted sample");

	// input only backs off when the output side is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// padding bits of the event word stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'd0)
		else $error("event padding not zero");

endmodule

bind multi_button_click_long_press_top mbk_checker u_mbk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_button_click_long_press_top
// A directed table of scan samples is followed by random press/hold/release
// gestures under several threshold and period settings. Every event is
// compared with an in-bench per-button key predictor, or for typed table
// rows with the row's own event. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_BTN     = 5;
	localparam int CYCLE_LIMIT = 200_000;

	// register indexes with no register behind them
	localparam logic [mbk_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [mbk_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// one row of the directed table; typed rows carry their own expected event
	typedef struct packed {
		logic [mbk_pkg::IDX_W-1:0] idx;
		logic                      lvl;     // 0 pressed, 1 released
		logic                      typed;
		logic [mbk_pkg::EV_W-1:0]  ev;
	} scan_row_t;

	// one random phase: register setting and how the gestures are shaped
	typedef struct {
		logic [mbk_pkg::CNT_W-1:0] thr;
		logic [mbk_pkg::CNT_W-1:0] per;
		int               items;      // in-range samples in the phase
		int               focus_pct;  // share of samples on one chosen button
		int               noise_pct;  // flipped levels and out-of-range indexes
		bit               calm;       // no idling on either side
	} phase_plan_t;

	localparam int DIR_ROWS = 20;
	localparam int NUM_PHASES = 7;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;   // [2:0] button_index, [3] pin_level
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [7:0]                    m_tdata;        // [1:0] key_event
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [mbk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mbk_pkg::CNT_W-1:0]     cfg_data = '0;

	// predictor state: own copy of the registers and the per-button machines
	logic [mbk_pkg::CNT_W-1:0]     exp_thr = mbk_pkg::CFG_RESET_VALUE;
	logic [mbk_pkg::CNT_W-1:0]     exp_per = mbk_pkg::CFG_RESET_VALUE;
	logic [mbk_pkg::PH_W-1:0]      btn_phase [NUM_BTN];
	logic [mbk_pkg::CNT_W-1:0]     btn_count [NUM_BTN];

	logic [mbk_pkg::EV_W-1:0]      pending_events [$];
	int                            mismatches = 0;
	int                            samples_sent = 0;
	int                            settings_used = 0;
	int                            events_seen [4] = '{default: 0};
	int                            cycle_count = 0;
	bit                            calm = 1'b0;

	scan_row_t                     dir_table [DIR_ROWS];
	phase_plan_t                   phases [NUM_PHASES];

	multi_button_click_long_press_top #(
		.NUM_BUTTONS(NUM_BTN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Run guard; also catches a block that stops answering.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver backpressure: about 15% stall cycles unless a calm stretch runs.
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 15);
	end

	// Per-button key machine. Updates the predictor state for one accepted
	// sample and returns the event it should cause.
	function automatic logic [mbk_pkg::EV_W-1:0] next_key_event(
		input logic [mbk_pkg::IDX_W-1:0] idx, input logic lvl);
		logic [mbk_pkg::PH_W-1:0]  ph;
		logic [mbk_pkg::CNT_W-1:0] cnt;
		logic [mbk_pkg::EV_W-1:0]  ev;
		ev = mbk_pkg::EV_NONE;
		// unknown buttons leave every machine alone
		if (int'(idx) >= NUM_BTN)
			return mbk_pkg::EV_NONE;
		ph  = btn_phase[idx];
		cnt = btn_count[idx];
		case (ph)
			mbk_pkg::PH_IDLE: begin
				if (!lvl)
					ph = mbk_pkg::PH_CONFIRM;
			end
			mbk_pkg::PH_CONFIRM: begin
				// second press sample in a row: debounce passed
				if (!lvl) begin
					ph  = mbk_pkg::PH_PRESSED;
					cnt = '0;
				end else begin
					ph = mbk_pkg::PH_IDLE;
				end
			end
			mbk_pkg::PH_PRESSED: begin
				if (lvl) begin
					ph = mbk_pkg::PH_IDLE;
					ev = mbk_pkg::EV_CLICK;
				end else begin
					cnt = cnt + 8'd1;
					// a zero threshold fires on the first counted sample
					if (cnt >= exp_thr) begin
						ph  = mbk_pkg::PH_LONG;
						cnt = '0;
						ev  = mbk_pkg::EV_HELD;
					end
				end
			end
			default: begin
				// release after a long press reports nothing
				if (lvl) begin
					ph = mbk_pkg::PH_IDLE;
				end else begin
					ev  = mbk_pkg::EV_HELD;
					cnt = cnt + 8'd1;
					if (cnt >= exp_per) begin
						cnt = '0;
						ev  = mbk_pkg::EV_REPEAT;
					end
				end
			end
		endcase
		btn_phase[idx] = ph;
		btn_count[idx] = cnt;
		return ev;
	endfunction

	// Drive one scan sample; tvalid stays high across back-to-back samples
	// and drops only for a random one-cycle gap. The expectation is queued at
	// the transfer edge.
	task automatic send_sample(input logic [mbk_pkg::IDX_W-1:0] idx, input logic lvl,
		input logic typed, input logic [mbk_pkg::EV_W-1:0] typed_ev);
		logic [mbk_pkg::EV_W-1:0] ev;
		if (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, lvl, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ev = next_key_event(idx, lvl);
		pending_events.push_back(typed ? typed_ev : ev);
		samples_sent++;
	endtask

	// Stop sending and wait until every queued event has come back.
	task automatic drain_events();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers, then a spare index with random data that must
	// not disturb anything. Valid stays high across the three transfers.
	task automatic load_settings(input logic [mbk_pkg::CNT_W-1:0] thr,
		input logic [mbk_pkg::CNT_W-1:0] per);
		logic [mbk_pkg::CFG_IDX_W-1:0] idx_list [3];
		logic [mbk_pkg::CNT_W-1:0]     val_list [3];
		idx_list[0] = mbk_pkg::REG_HOLD_THRESHOLD;
		val_list[0] = thr;
		idx_list[1] = mbk_pkg::REG_REPEAT_PERIOD;
		val_list[1] = per;
		idx_list[2] = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
		val_list[2] = mbk_pkg::CNT_W'($urandom_range(255));
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[k];
			cfg_data  <= val_list[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			if (idx_list[k] == mbk_pkg::REG_HOLD_THRESHOLD)
				exp_thr = val_list[k];
			else if (idx_list[k] == mbk_pkg::REG_REPEAT_PERIOD)
				exp_per = val_list[k];
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Random gestures: every button works through a planned run of press
	// samples, then releases and plans the next run. Short runs give glitches
	// and clicks, long ones long presses, held reports and repeat ticks.
	task automatic run_phase(input phase_plan_t pl, input int slot);
		int               press_left [NUM_BTN];
		int               done_in_range;
		int               b;
		int               thr_i;
		int               per_i;
		logic             lvl;
		press_left    = '{default: 0};
		done_in_range = 0;
		thr_i         = int'(pl.thr);
		per_i         = int'(pl.per);
		drain_events();
		load_settings(pl.thr, pl.per);
		calm = pl.calm;
		while (done_in_range < pl.items) begin
			if ($urandom_range(99) < pl.noise_pct) begin
				// sample for a button that does not exist
				send_sample(mbk_pkg::IDX_W'($urandom_range(NUM_BTN, 7)),
					1'($urandom_range(1)), 1'b0, mbk_pkg::EV_NONE);
			end else begin
				b = ($urandom_range(99) < pl.focus_pct) ? slot % NUM_BTN
					: $urandom_range(NUM_BTN - 1);
				if (press_left[b] > 0) begin
					lvl = 1'b0;
					press_left[b]--;
				end else begin
					lvl = 1'b1;
					press_left[b] = $urandom_range(1) ? $urandom_range(0, thr_i + 2)
						: $urandom_range(thr_i + 2, thr_i + 4 + 2 * per_i);
				end
				// noise breaks a running gesture
				if ($urandom_range(99) < pl.noise_pct)
					lvl = ~lvl;
				send_sample(mbk_pkg::IDX_W'(b), lvl, 1'b0, mbk_pkg::EV_NONE);
				done_in_range++;
			end
		end
		calm = 1'b0;
	endtask

	// Event checker: each transfer against the oldest expectation.
	always @(posedge clk) begin : event_check
		logic [mbk_pkg::EV_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$error("key_event: transfer with nothing expected, actual %0d",
					m_tdata[mbk_pkg::EV_W-1:0]);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				events_seen[m_tdata[mbk_pkg::EV_W-1:0]]++;
				if (m_tdata[mbk_pkg::EV_W-1:0] !== want) begin
					$error("key_event: expected %0d, actual %0d", want,
						m_tdata[mbk_pkg::EV_W-1:0]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_BTN; i++) begin
			btn_phase[i] = mbk_pkg::PH_IDLE;
			btn_count[i] = '0;
		end

		// Directed table, run with zero threshold and zero period:
		// debounce, immediate long press, repeat on every held sample,
		// click, glitch rejection and indexes past the last button.
		dir_table = '{
			'{3'd0, 1'b0, 1'b1, mbk_pkg::EV_NONE},    // idle -> confirm
			'{3'd0, 1'b0, 1'b1, mbk_pkg::EV_NONE},    // confirm -> pressed
			'{3'd0, 1'b0, 1'b1, mbk_pkg::EV_HELD},    // zero threshold: long press at once
			'{3'd0, 1'b0, 1'b1, mbk_pkg::EV_REPEAT},  // zero period: every sample repeats
			'{3'd0, 1'b0, 1'b1, mbk_pkg::EV_REPEAT},
			'{3'd1, 1'b0, 1'b1, mbk_pkg::EV_NONE},    // other button, own machine
			'{3'd0, 1'b1, 1'b1, mbk_pkg::EV_NONE},    // release after long press: silent
			'{3'd1, 1'b1, 1'b1, mbk_pkg::EV_NONE},    // single-sample glitch dropped
			'{3'd5, 1'b0, 1'b1, mbk_pkg::EV_NONE},    // past the last button
			'{3'd7, 1'b1, 1'b1, mbk_pkg::EV_NONE},
			'{3'd6, 1'b0, 1'b1, mbk_pkg::EV_NONE},
			'{3'd4, 1'b0, 1'b1, mbk_pkg::EV_NONE},
			'{3'd4, 1'b0, 1'b1, mbk_pkg::EV_NONE},
			'{3'd4, 1'b1, 1'b1, mbk_pkg::EV_CLICK},   // release from pressed
			'{3'd3, 1'b1, 1'b1, mbk_pkg::EV_NONE},    // release while idle
			'{3'd2, 1'b0, 1'b0, mbk_pkg::EV_NONE},
			'{3'd2, 1'b0, 1'b0, mbk_pkg::EV_NONE},
			'{3'd2, 1'b0, 1'b0, mbk_pkg::EV_NONE},
			'{3'd2, 1'b0, 1'b0, mbk_pkg::EV_NONE},
			'{3'd2, 1'b1, 1'b0, mbk_pkg::EV_NONE}
		};

		// Random phases. The large settings put nearly all samples on one
		// button so that its hold can reach the threshold and the period.
		phases = '{
			'{8'd100, 8'd100, 250, 90,  0, 1'b0},
			'{8'd1,   8'd1,   150, 20,  8, 1'b0},
			'{8'd2,   8'd3,   150, 20,  8, 1'b0},
			'{8'd255, 8'd2,   350, 95,  0, 1'b0},
			'{8'd3,   8'd255, 400, 95,  0, 1'b1},  // long stretch without idling
			'{8'd0,   8'd5,   100, 20,  8, 1'b0},
			'{8'd6,   8'd0,   100, 20,  8, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_settings(8'd0, 8'd0);
		for (int r = 0; r < DIR_ROWS; r++)
			send_sample(dir_table[r].idx, dir_table[r].lvl, dir_table[r].typed, dir_table[r].ev);

		for (int p = 0; p < NUM_PHASES; p++)
			run_phase(phases[p], p);

		drain_events();
		// wait on so that stray events still get caught
		repeat (8) @(posedge clk);

		$display("Ran %0d scan samples under %0d register settings.",
			samples_sent, settings_used);
		$display("Events checked: %0d none, %0d click, %0d long/held, %0d repeat.",
			events_seen[mbk_pkg::EV_NONE], events_seen[mbk_pkg::EV_CLICK],
			events_seen[mbk_pkg::EV_HELD], events_seen[mbk_pkg::EV_REPEAT]);
		if (mismatches == 0 && pending_events.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
